// ===== hw/rtl/hid_to_ps2_set2_translator_defines.svh =====
// Assertion macros for the HID to PS/2 set 2 translator.
// Used by hid_to_ps2_set2_translator.sv; depends on nothing else.
`ifndef HID_TO_PS2_SET2_TRANSLATOR_DEFINES_SVH
`define HID_TO_PS2_SET2_TRANSLATOR_DEFINES_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define H2PS2_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked at every rising clock edge outside reset.
`define H2PS2_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hw/rtl/h2ps2_pkg.sv =====
// Types, constants and the usage-to-make-code table of the HID to PS/2 set 2 translator.
// Depends on nothing; imported by hid_to_ps2_set2_translator.
package h2ps2_pkg;

   typedef logic [7:0] code_type;

   typedef struct packed {
      logic     mapped;
      logic     extended;
      code_type make;
   } key_entry_type;

   // longest byte run of one key event (Pause release)
   localparam int RunDepth      = 7;
   localparam int RunCountWidth = 3;

   typedef logic [RunCountWidth-1:0] run_count_type;

   localparam code_type UsagePrintScreen = 8'h46;
   localparam code_type UsagePause       = 8'h48;

   localparam code_type CodeBreak    = 8'hF0;
   localparam code_type CodeExtend   = 8'hE0;
   localparam code_type CodePause    = 8'hE1;
   localparam code_type CodePrtScr   = 8'h7C;
   localparam code_type CodeLShift   = 8'h12;
   localparam code_type CodeLCtrl    = 8'h14;
   localparam code_type CodeNumLock  = 8'h77;

   function automatic key_entry_type k(input code_type c);
      return '{mapped: 1'b1, extended: 1'b0, make: c};
   endfunction

   function automatic key_entry_type ke(input code_type c);
      return '{mapped: 1'b1, extended: 1'b1, make: c};
   endfunction

   function automatic key_entry_type key_lookup(input code_type usage);
      key_entry_type e;
      case (usage)
         8'h04: e = k(8'h1C);  8'h05: e = k(8'h32);  8'h06: e = k(8'h21);
         8'h07: e = k(8'h23);  8'h08: e = k(8'h24);  8'h09: e = k(8'h2B);
         8'h0A: e = k(8'h34);  8'h0B: e = k(8'h33);  8'h0C: e = k(8'h43);
         8'h0D: e = k(8'h3B);  8'h0E: e = k(8'h42);  8'h0F: e = k(8'h4B);
         8'h10: e = k(8'h3A);  8'h11: e = k(8'h31);  8'h12: e = k(8'h44);
         8'h13: e = k(8'h4D);  8'h14: e = k(8'h15);  8'h15: e = k(8'h2D);
         8'h16: e = k(8'h1B);  8'h17: e = k(8'h2C);  8'h18: e = k(8'h3C);
         8'h19: e = k(8'h2A);  8'h1A: e = k(8'h1D);  8'h1B: e = k(8'h22);
         8'h1C: e = k(8'h35);  8'h1D: e = k(8'h1A);
         8'h1E: e = k(8'h16);  8'h1F: e = k(8'h1E);  8'h20: e = k(8'h26);
         8'h21: e = k(8'h25);  8'h22: e = k(8'h2E);  8'h23: e = k(8'h36);
         8'h24: e = k(8'h3D);  8'h25: e = k(8'h3E);  8'h26: e = k(8'h46);
         8'h27: e = k(8'h45);
         8'h28: e = k(8'h5A);  8'h29: e = k(8'h76);  8'h2A: e = k(8'h66);
         8'h2B: e = k(8'h0D);  8'h2C: e = k(8'h29);  8'h2D: e = k(8'h4E);
         8'h2E: e = k(8'h55);  8'h2F: e = k(8'h54);  8'h30: e = k(8'h5B);
         8'h31: e = k(8'h5D);  8'h33: e = k(8'h4C);  8'h34: e = k(8'h52);
         8'h35: e = k(8'h0E);  8'h36: e = k(8'h41);  8'h37: e = k(8'h49);
         8'h38: e = k(8'h4A);  8'h39: e = k(8'h58);
         8'h3A: e = k(8'h05);  8'h3B: e = k(8'h06);  8'h3C: e = k(8'h04);
         8'h3D: e = k(8'h0C);  8'h3E: e = k(8'h03);  8'h3F: e = k(8'h0B);
         8'h40: e = k(8'h83);  8'h41: e = k(8'h0A);  8'h42: e = k(8'h01);
         8'h43: e = k(8'h09);  8'h44: e = k(8'h78);  8'h45: e = k(8'h07);
         8'h47: e = k(8'h7E);
         8'h49: e = ke(8'h70); 8'h4A: e = ke(8'h6C); 8'h4B: e = ke(8'h7D);
         8'h4C: e = ke(8'h71); 8'h4D: e = ke(8'h69); 8'h4E: e = ke(8'h7A);
         8'h4F: e = ke(8'h74); 8'h50: e = ke(8'h6B); 8'h51: e = ke(8'h72);
         8'h52: e = ke(8'h75);
         8'h53: e = k(8'h77);  8'h54: e = ke(8'h4A); 8'h55: e = k(8'h7C);
         8'h56: e = k(8'h7B);  8'h57: e = k(8'h79);  8'h58: e = ke(8'h5A);
         8'h59: e = k(8'h69);  8'h5A: e = k(8'h72);  8'h5B: e = k(8'h7A);
         8'h5C: e = k(8'h6B);  8'h5D: e = k(8'h73);  8'h5E: e = k(8'h74);
         8'h5F: e = k(8'h6C);  8'h60: e = k(8'h75);  8'h61: e = k(8'h7D);
         8'h62: e = k(8'h70);  8'h63: e = k(8'h71);
         8'h65: e = ke(8'h2F);
         8'hE0: e = k(8'h14);  8'hE1: e = k(8'h12);  8'hE2: e = k(8'h11);
         8'hE3: e = ke(8'h1F); 8'hE4: e = ke(8'h14); 8'hE5: e = k(8'h59);
         8'hE6: e = ke(8'h11); 8'hE7: e = ke(8'h27);
         default: e = '0;
      endcase
      return e;
   endfunction

endpackage

// ===== hw/rtl/hid_to_ps2_set2_translator.sv =====
// Top level of the HID usage to PS/2 scan code set 2 translator.
// Depends on h2ps2_pkg and hid_to_ps2_set2_translator_defines.svh.
//
//   channel   ports                                   handshake
//   -------   -------------------------------------   ------------------------------
//   request   req_key_usage[7:0], req_is_release      start high while busy low
//   response  rsp_code_byte[7:0], rsp_last_of_run     rsp_strobe, high with each byte
//
// A key event is registered on acceptance, decoded in the next cycle into a byte run
// of 0 to 7 bytes, and the run is shifted out one byte per cycle from a run buffer.
// The first byte shows once the run buffer has loaded the decoded run. The buffer
// takes a new run only when empty or showing its final byte; until then the next
// event waits decoded in the input register, and busy rises while it waits. The
// receiver cannot stall; reset is synchronous and clears only control.
`include "hid_to_ps2_set2_translator_defines.svh"

module hid_to_ps2_set2_translator
   import h2ps2_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   input  logic [7:0] req_key_usage,
   input  logic       req_is_release,
   output logic       rsp_strobe,
   output logic [7:0] rsp_code_byte,
   output logic       rsp_last_of_run
);

   // input register
   logic          ev_valid_ff, ev_valid_in;
   code_type      ev_usage_ff;
   logic          ev_release_ff;

   // run buffer: byte 0 is on the response ports, count is bytes still to go
   code_type      run_ff [RunDepth];
   code_type      run_in [RunDepth];
   run_count_type run_count_ff, run_count_in;

   // decode of the registered event
   code_type      dec_run [RunDepth];
   run_count_type dec_count;
   key_entry_type dec_entry;

   logic accept;
   logic load_run;

   // the buffer takes a new run once it is empty or showing its final byte
   assign load_run = ev_valid_ff && (run_count_ff <= run_count_type'(1));
   assign busy     = ev_valid_ff && !load_run;
   assign accept   = start && !busy;

   assign ev_valid_in = accept || (ev_valid_ff && !load_run);

   always_ff @(posedge clock) begin
      if (reset) begin
         ev_valid_ff <= 1'b0;
      end else begin
         ev_valid_ff <= ev_valid_in;
      end
   end

   // hold the event payload until the next acceptance
   always_ff @(posedge clock) begin
      if (accept) begin
         ev_usage_ff   <= req_key_usage;
         ev_release_ff <= req_is_release;
      end
   end

   // decode one event into its full byte run
   always_comb begin
      dec_entry = key_lookup(ev_usage_ff);
      for (int i = 0; i < RunDepth; i++) begin
         dec_run[i] = '0;
      end
      dec_count = '0;
      if (ev_usage_ff == UsagePrintScreen) begin
         if (!ev_release_ff) begin
            dec_run[0] = CodeExtend;
            dec_run[1] = CodeLShift;
            dec_run[2] = CodeExtend;
            dec_run[3] = CodePrtScr;
            dec_count  = run_count_type'(4);
         end else begin
            dec_run[0] = CodeExtend;
            dec_run[1] = CodeBreak;
            dec_run[2] = CodePrtScr;
            dec_run[3] = CodeExtend;
            dec_run[4] = CodeBreak;
            dec_run[5] = CodeLShift;
            dec_count  = run_count_type'(6);
         end
      end else if (ev_usage_ff == UsagePause) begin
         // Pause repeats ctrl/numlock twice; on release, break codes sit before each numlock
         dec_run[0] = CodePause;
         if (!ev_release_ff) begin
            dec_run[1] = CodeLCtrl;
            dec_run[2] = CodeNumLock;
            dec_run[3] = CodeLCtrl;
            dec_run[4] = CodeNumLock;
            dec_count  = run_count_type'(5);
         end else begin
            dec_run[1] = CodeLCtrl;
            dec_run[2] = CodeBreak;
            dec_run[3] = CodeNumLock;
            dec_run[4] = CodeLCtrl;
            dec_run[5] = CodeBreak;
            dec_run[6] = CodeNumLock;
            dec_count  = run_count_type'(7);
         end
      end else if (dec_entry.mapped) begin
         if (dec_entry.extended && ev_release_ff) begin
            dec_run[0] = CodeExtend;
            dec_run[1] = CodeBreak;
            dec_run[2] = dec_entry.make;
            dec_count  = run_count_type'(3);
         end else if (dec_entry.extended) begin
            dec_run[0] = CodeExtend;
            dec_run[1] = dec_entry.make;
            dec_count  = run_count_type'(2);
         end else if (ev_release_ff) begin
            dec_run[0] = CodeBreak;
            dec_run[1] = dec_entry.make;
            dec_count  = run_count_type'(2);
         end else begin
            dec_run[0] = dec_entry.make;
            dec_count  = run_count_type'(1);
         end
      end
   end

   // load a fresh run, or advance the current one by one byte
   always_comb begin
      if (load_run) begin
         run_in       = dec_run;
         run_count_in = dec_count;
      end else begin
         for (int i = 0; i < RunDepth - 1; i++) begin
            run_in[i] = run_ff[i+1];
         end
         run_in[RunDepth-1] = run_ff[RunDepth-1];
         run_count_in = (run_count_ff != '0) ? run_count_ff - run_count_type'(1) : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_count_ff <= '0;
      end else begin
         run_count_ff <= run_count_in;
      end
   end

   always_ff @(posedge clock) begin
      run_ff <= run_in;
   end

   assign rsp_strobe      = (run_count_ff != '0);
   assign rsp_code_byte   = run_ff[0];
   assign rsp_last_of_run = (run_count_ff == run_count_type'(1));

   // a run is never cut short by a new load
   `H2PS2_ASSERT_NOW(a_load_only_at_end, clock, reset, load_run,
      run_count_ff <= run_count_type'(1), "run buffer reloaded mid-run")
   // a byte that is not last is always followed by another byte
   `H2PS2_ASSERT_NEXT(a_run_unbroken, clock, reset, rsp_strobe && !rsp_last_of_run,
      rsp_strobe, "byte run broken before its last byte")
   // an accepted event is decoded in the next cycle
   `H2PS2_ASSERT_NEXT(a_accept_registers, clock, reset, accept, ev_valid_ff,
      "accepted event not registered")
   // the run length never exceeds the longest sequence
   `H2PS2_ASSERT_NOW(a_count_bound, clock, reset, 1'b1,
      run_count_ff <= run_count_type'(RunDepth), "run count out of range")

endmodule

// ===== dv/hid_to_ps2_set2_translator_test.sv =====
// Self-checking testbench for the HID usage to PS/2 set 2 translator.
// Depends on h2ps2_pkg and hid_to_ps2_set2_translator; a scoreboard class predicts runs.
module hid_to_ps2_set2_translator_test
   import h2ps2_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   // bounds on sender idling and end-of-run settling
   localparam int BurstMax    = 8;
   localparam int GapMax      = 12;
   localparam int SettleTail  = 20;
   localparam int RandomRuns  = 70;
   localparam int StallLimit  = 400;

   typedef struct {
      code_type usage;
      bit       release_key;
   } key_event_type;

   typedef struct {
      code_type code;
      bit       last;
   } set2_byte_type;

   // Set 2 make code of one usage: {mapped, extended, make}. Zero when unmapped.
   function automatic logic [9:0] set2_make_of(input code_type usage);
      code_type mk;
      bit       mapped;
      bit       ext;
      mapped = 1'b1;
      mk     = '0;
      case (usage)
         // letters a..z
         8'h04: mk = 8'h1C;
         8'h05: mk = 8'h32;
         8'h06: mk = 8'h21;
         8'h07: mk = 8'h23;
         8'h08: mk = 8'h24;
         8'h09: mk = 8'h2B;
         8'h0A: mk = 8'h34;
         8'h0B: mk = 8'h33;
         8'h0C: mk = 8'h43;
         8'h0D: mk = 8'h3B;
         8'h0E: mk = 8'h42;
         8'h0F: mk = 8'h4B;
         8'h10: mk = 8'h3A;
         8'h11: mk = 8'h31;
         8'h12: mk = 8'h44;
         8'h13: mk = 8'h4D;
         8'h14: mk = 8'h15;
         8'h15: mk = 8'h2D;
         8'h16: mk = 8'h1B;
         8'h17: mk = 8'h2C;
         8'h18: mk = 8'h3C;
         8'h19: mk = 8'h2A;
         8'h1A: mk = 8'h1D;
         8'h1B: mk = 8'h22;
         8'h1C: mk = 8'h35;
         8'h1D: mk = 8'h1A;
         // digit row 1..0
         8'h1E: mk = 8'h16;
         8'h1F: mk = 8'h1E;
         8'h20: mk = 8'h26;
         8'h21: mk = 8'h25;
         8'h22: mk = 8'h2E;
         8'h23: mk = 8'h36;
         8'h24: mk = 8'h3D;
         8'h25: mk = 8'h3E;
         8'h26: mk = 8'h46;
         8'h27: mk = 8'h45;
         // enter, escape, backspace, tab, space, punctuation
         8'h28: mk = 8'h5A;
         8'h29: mk = 8'h76;
         8'h2A: mk = 8'h66;
         8'h2B: mk = 8'h0D;
         8'h2C: mk = 8'h29;
         8'h2D: mk = 8'h4E;
         8'h2E: mk = 8'h55;
         8'h2F: mk = 8'h54;
         8'h30: mk = 8'h5B;
         8'h31: mk = 8'h5D;
         8'h33: mk = 8'h4C;
         8'h34: mk = 8'h52;
         8'h35: mk = 8'h0E;
         8'h36: mk = 8'h41;
         8'h37: mk = 8'h49;
         8'h38: mk = 8'h4A;
         8'h39: mk = 8'h58;
         // function keys F1..F12, scroll lock
         8'h3A: mk = 8'h05;
         8'h3B: mk = 8'h06;
         8'h3C: mk = 8'h04;
         8'h3D: mk = 8'h0C;
         8'h3E: mk = 8'h03;
         8'h3F: mk = 8'h0B;
         8'h40: mk = 8'h83;
         8'h41: mk = 8'h0A;
         8'h42: mk = 8'h01;
         8'h43: mk = 8'h09;
         8'h44: mk = 8'h78;
         8'h45: mk = 8'h07;
         8'h47: mk = 8'h7E;
         // navigation cluster
         8'h49: mk = 8'h70;
         8'h4A: mk = 8'h6C;
         8'h4B: mk = 8'h7D;
         8'h4C: mk = 8'h71;
         8'h4D: mk = 8'h69;
         8'h4E: mk = 8'h7A;
         8'h4F: mk = 8'h74;
         8'h50: mk = 8'h6B;
         8'h51: mk = 8'h72;
         8'h52: mk = 8'h75;
         // keypad
         8'h53: mk = 8'h77;
         8'h54: mk = 8'h4A;
         8'h55: mk = 8'h7C;
         8'h56: mk = 8'h7B;
         8'h57: mk = 8'h79;
         8'h58: mk = 8'h5A;
         8'h59: mk = 8'h69;
         8'h5A: mk = 8'h72;
         8'h5B: mk = 8'h7A;
         8'h5C: mk = 8'h6B;
         8'h5D: mk = 8'h73;
         8'h5E: mk = 8'h74;
         8'h5F: mk = 8'h6C;
         8'h60: mk = 8'h75;
         8'h61: mk = 8'h7D;
         8'h62: mk = 8'h70;
         8'h63: mk = 8'h71;
         8'h65: mk = 8'h2F;
         // modifiers
         8'hE0: mk = 8'h14;
         8'hE1: mk = 8'h12;
         8'hE2: mk = 8'h11;
         8'hE3: mk = 8'h1F;
         8'hE4: mk = 8'h14;
         8'hE5: mk = 8'h59;
         8'hE6: mk = 8'h11;
         8'hE7: mk = 8'h27;
         default: mapped = 1'b0;
      endcase
      case (usage)
         8'h49, 8'h4A, 8'h4B, 8'h4C, 8'h4D, 8'h4E, 8'h4F, 8'h50, 8'h51, 8'h52,
         8'h54, 8'h58, 8'h65, 8'hE3, 8'hE4, 8'hE6, 8'hE7: ext = 1'b1;
         default: ext = 1'b0;
      endcase
      return {mapped, ext, mk};
   endfunction

   function automatic bit makes_bytes(input code_type usage);
      logic [9:0] entry;
      entry = set2_make_of(usage);
      return (usage == UsagePrintScreen) || (usage == UsagePause) || entry[9];
   endfunction

   // Holds the bytes still owed by the block, oldest first.
   class set2_scoreboard_type;
      set2_byte_type owed[$];
      int            errors;

      function new();
         errors = 0;
      endfunction

      // Append the full byte run of one accepted key event.
      function void note_key_event(input code_type usage, input bit release_key);
         code_type      run[$];
         logic [9:0]    entry;
         set2_byte_type b;
         if (usage == UsagePrintScreen) begin
            if (!release_key)
               run = '{CodeExtend, CodeLShift, CodeExtend, CodePrtScr};
            else
               run = '{CodeExtend, CodeBreak, CodePrtScr, CodeExtend, CodeBreak, CodeLShift};
         end else if (usage == UsagePause) begin
            run.push_back(CodePause);
            repeat (2) begin
               run.push_back(CodeLCtrl);
               if (release_key) run.push_back(CodeBreak);
               run.push_back(CodeNumLock);
            end
         end else begin
            entry = set2_make_of(usage);
            if (entry[9]) begin
               if (entry[8]) run.push_back(CodeExtend);
               if (release_key) run.push_back(CodeBreak);
               run.push_back(entry[7:0]);
            end
         end
         foreach (run[i]) begin
            b.code = run[i];
            b.last = (i == run.size() - 1);
            owed.push_back(b);
         end
      endfunction

      // Compare one strobed byte with the oldest owed byte.
      function void check_byte(input code_type code, input bit last);
         set2_byte_type want;
         if (owed.size() == 0) begin
            $display("%0t: unexpected byte, expected none, actual code %h last %b",
                     $time, code, last);
            errors++;
            return;
         end
         want = owed.pop_front();
         if (code !== want.code) begin
            $display("%0t: code_byte mismatch, expected %h, actual %h",
                     $time, want.code, code);
            errors++;
         end
         if (last !== want.last) begin
            $display("%0t: last_of_run mismatch, expected %b, actual %b",
                     $time, want.last, last);
            errors++;
         end
      endfunction

      function int outstanding();
         return owed.size();
      endfunction
   endclass

   logic       clock;
   logic       reset;
   logic       start;
   logic       busy;
   logic [7:0] req_key_usage;
   logic       req_is_release;
   logic       rsp_strobe;
   logic [7:0] rsp_code_byte;
   logic       rsp_last_of_run;

   set2_scoreboard_type board;
   int                  quiet_cycles;

   hid_to_ps2_set2_translator dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_key_usage   (req_key_usage),
      .req_is_release  (req_is_release),
      .rsp_strobe      (rsp_strobe),
      .rsp_code_byte   (rsp_code_byte),
      .rsp_last_of_run (rsp_last_of_run)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Check every strobed byte at the edge that accepts it.
   always @(posedge clock) begin
      if (!reset && rsp_strobe === 1'b1) board.check_byte(rsp_code_byte, rsp_last_of_run);
   end

   // Watchdog: count cycles in which neither a word goes in nor a byte comes out.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= StallLimit) begin
            $display("*** FAILED ***");
            $finish;
         end
      end
   end

   // Present one key event at a falling edge and hold it until the block takes it.
   // Leave start high on return; the caller lowers it if a gap follows.
   task automatic send_key(input code_type usage, input bit release_key);
      start          = 1'b1;
      req_key_usage  = usage;
      req_is_release = release_key;
      @(posedge clock);
      while (busy) @(posedge clock);
      board.note_key_event(usage, release_key);
      @(negedge clock);
   endtask

   // Stop sending, wait for every owed byte, then wait out the settling tail so that
   // a run that makes no bytes can show any stray output.
   task automatic drain_block();
      start = 1'b0;
      while (board.outstanding() != 0) @(negedge clock);
      repeat (SettleTail) @(negedge clock);
   endtask

   // Pick a random key event; mostly mapped keys, some special keys, some anything.
   task automatic pick_key(output code_type usage, output bit release_key);
      int sel;
      sel         = $urandom_range(0, 9);
      release_key = 1'($urandom_range(0, 1));
      if (sel == 0) begin
         usage = ($urandom_range(0, 1) != 0) ? UsagePause : UsagePrintScreen;
      end else if (sel <= 2) begin
         usage = code_type'($urandom_range(0, 255));
      end else begin
         usage = code_type'($urandom_range(0, 255));
         while (!makes_bytes(usage)) usage = code_type'($urandom_range(0, 255));
      end
   endtask

   initial begin
      key_event_type directed[$];
      code_type      usage;
      bit            release_key;
      int            runs_sent;
      int            burst_len;
      int            gap;
      bit            paused;

      board          = new();
      quiet_cycles   = 0;
      reset          = 1'b1;
      start          = 1'b0;
      req_key_usage  = '0;
      req_is_release = 1'b0;
      repeat (6) @(negedge clock);
      reset = 1'b0;

      // Directed: field extremes, ordinary and extended keys, both special
      // sequences, unmapped usages, the F7 make code above 0x7F.
      directed = '{
         '{8'h00, 1'b0}, '{8'hFF, 1'b1}, '{8'h04, 1'b0}, '{8'h04, 1'b1},
         '{8'h49, 1'b0}, '{8'h49, 1'b1}, '{8'hE7, 1'b0}, '{8'hE7, 1'b1},
         '{UsagePrintScreen, 1'b0}, '{UsagePrintScreen, 1'b1},
         '{UsagePause, 1'b0}, '{UsagePause, 1'b1},
         '{8'h40, 1'b0}, '{8'h40, 1'b1}, '{8'h32, 1'b0}, '{8'h64, 1'b1},
         '{8'hE8, 1'b0}, '{8'h7F, 1'b1}, '{8'h80, 1'b0}, '{UsagePause, 1'b1},
         '{8'h01, 1'b0}, '{8'hE0, 1'b1}
      };
      // back-to-back first, so that long runs queue up behind each other
      foreach (directed[i]) send_key(directed[i].usage, directed[i].release_key);
      drain_block();

      // Random bursts with random gaps; every third burst or so runs with no gap.
      runs_sent = 0;
      paused    = 1'b0;
      while (runs_sent < RandomRuns) begin
         burst_len = $urandom_range(1, BurstMax);
         repeat (burst_len) begin
            pick_key(usage, release_key);
            send_key(usage, release_key);
            if (makes_bytes(usage)) runs_sent++;
         end
         // once halfway, hold off until every owed byte has arrived
         if (!paused && runs_sent >= RandomRuns / 2) begin
            paused = 1'b1;
            drain_block();
         end
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, GapMax);
         if (gap > 0) begin
            start = 1'b0;
            repeat (gap) @(negedge clock);
         end
      end

      drain_block();
      if (board.errors == 0 && board.outstanding() == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
